// ----- rtl/rpi_pkg.sv -----
// shared types, widths and constants of the ray/primitive intersection pipeline
`timescale 1ns / 1ps
package rpi_pkg;

  // ray coordinate format
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 16;

  // transform rows: four signed q8.8 lanes
  localparam int LANE_W    = 16;
  localparam int LANE_FRAC = 8;
  localparam int ROW_W     = 4 * LANE_W;

  // object-space values carry eight extra integer bits
  localparam int OBJ_W     = COORD_W + 8;
  localparam int PH_W      = OBJ_W + 1;
  localparam int PR_W      = LANE_W + COORD_W;
  localparam int MAP_W     = PR_W + 2;

  // wide multiplier operand and product
  localparam int MW        = 2 * OBJ_W + 4;
  localparam int LIMB_W    = (MW + 2) / 3;
  localparam int MAG_W     = 3 * LIMB_W;
  localparam int PW        = 2 * MW;
  localparam int MUL_LAT   = 5;

  // square root and division
  localparam int ROOT_W    = MW - 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int NUM_W     = MW + FRAC_W + 4;
  localparam int DIV_LAT   = COORD_W + 3;

  // request accepted to result strobe sampled
  localparam int PIPE_LAT  = 6 + 2 * MUL_LAT + ROOT_W + DIV_LAT;

  // configuration registers
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int EPS_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_KIND = 3'd3,
    REG_EPS  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    PRIM_SPHERE = 1'b0,
    PRIM_PLANE  = 1'b1
  } prim_e;

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'h0000_0000_0000_0100);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'h0000_0000_0100_0000);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'h0000_0100_0000_0000);
  localparam logic [EPS_W-1:0] EPS_RST  = EPS_W'(7);

  localparam logic [1:0] HITS_NONE   = 2'd0;
  localparam logic [1:0] HITS_PLANE  = 2'd1;
  localparam logic [1:0] HITS_SPHERE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } rpi_req_t;

  typedef struct packed {
    logic        [1:0]         hit_count;
    logic signed [COORD_W-1:0] t_near;
    logic signed [COORD_W-1:0] t_far;
  } rpi_res_t;

endpackage

// ----- rtl/rpi_mul.sv -----
// pipelined signed multiplier built from 3x3 limb partial products
`timescale 1ns / 1ps
module rpi_mul import rpi_pkg::*; (
  input  logic                 clk_i,
  input  logic signed [MW-1:0] a_i,
  input  logic signed [MW-1:0] b_i,
  output logic signed [PW-1:0] p_o
);

  localparam int ROW_SUM_W = 4 * LIMB_W + 2;
  localparam int MAGP_W    = 2 * MAG_W;

  logic [MW-1:0]          a_abs, b_abs;
  logic [MAG_W-1:0]       am_q, bm_q;
  logic [3:0]             neg_q;
  logic [2*LIMB_W-1:0]    pp_q [3][3];
  logic [ROW_SUM_W-1:0]   row_q [3];
  logic [MAGP_W-1:0]      mag_q;
  logic signed [PW-1:0]   p_q;

  assign a_abs = a_i[MW-1] ? MW'(-a_i) : MW'(a_i);
  assign b_abs = b_i[MW-1] ? MW'(-b_i) : MW'(b_i);

  always_ff @(posedge clk_i) begin
    // magnitudes and product sign
    am_q     <= MAG_W'(a_abs);
    bm_q     <= MAG_W'(b_abs);
    neg_q[0] <= a_i[MW-1] ^ b_i[MW-1];
    neg_q[3:1] <= neg_q[2:0];
    // limb products
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_q[i][j] <= am_q[i*LIMB_W +: LIMB_W] * bm_q[j*LIMB_W +: LIMB_W];
      end
    end
    // row sums
    for (int i = 0; i < 3; i++) begin
      row_q[i] <= ROW_SUM_W'(pp_q[i][0])
                + (ROW_SUM_W'(pp_q[i][1]) << LIMB_W)
                + (ROW_SUM_W'(pp_q[i][2]) << (2 * LIMB_W));
    end
    mag_q <= MAGP_W'(row_q[0])
           + (MAGP_W'(row_q[1]) << LIMB_W)
           + (MAGP_W'(row_q[2]) << (2 * LIMB_W));
    p_q   <= neg_q[3] ? -$signed(PW'(mag_q)) : $signed(PW'(mag_q));
  end

  assign p_o = p_q;

endmodule

// ----- rtl/rpi_div.sv -----
// pipelined floor divider, one quotient bit per stage, saturated result
`timescale 1ns / 1ps
module rpi_div import rpi_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [NUM_W-1:0]   num_i,
  input  logic        [MW-1:0]      den_i,
  output logic signed [COORD_W-1:0] q_o
);

  localparam int CMP_W = MW + COORD_W;

  logic [NUM_W-1:0]   m_abs;
  logic [NUM_W-1:0]   m1_q;
  logic [MW-1:0]      d1_q;
  logic               n1_q;

  logic [NUM_W-1:0]   rem_q [COORD_W+1];
  logic [COORD_W-1:0] qt_q  [COORD_W+1];
  logic [MW-1:0]      dv_q  [COORD_W+1];
  logic               ng_q  [COORD_W+1];
  logic               ov_q  [COORD_W+1];

  logic [COORD_W-1:0] qm;
  logic [COORD_W:0]   tot;
  logic signed [COORD_W-1:0] q_d, q_q;

  localparam logic [COORD_W-1:0] QMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] QMIN = {1'b1, {(COORD_W-1){1'b0}}};

  assign m_abs = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  always_ff @(posedge clk_i) begin
    m1_q <= m_abs;
    d1_q <= den_i;
    n1_q <= num_i[NUM_W-1];
    // quotient of 2^COORD_W or more saturates either way
    ov_q[0]  <= CMP_W'(m1_q) >= (CMP_W'(d1_q) << COORD_W);
    rem_q[0] <= m1_q;
    qt_q[0]  <= '0;
    dv_q[0]  <= d1_q;
    ng_q[0]  <= n1_q;
  end

  for (genvar k = 0; k < COORD_W; k++) begin : g_step
    localparam int Sh = COORD_W - 1 - k;
    logic [CMP_W-1:0] trial, wrem;
    assign trial = CMP_W'(dv_q[k]) << Sh;
    assign wrem  = CMP_W'(rem_q[k]);
    always_ff @(posedge clk_i) begin
      if (wrem >= trial) begin
        rem_q[k+1] <= NUM_W'(wrem - trial);
        qt_q[k+1]  <= {qt_q[k][COORD_W-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= rem_q[k];
        qt_q[k+1]  <= {qt_q[k][COORD_W-2:0], 1'b0};
      end
      dv_q[k+1] <= dv_q[k];
      ng_q[k+1] <= ng_q[k];
      ov_q[k+1] <= ov_q[k];
    end
  end

  // floor toward minus infinity for negative numerators
  always_comb begin
    qm  = qt_q[COORD_W];
    tot = {1'b0, qm} + (COORD_W+1)'(rem_q[COORD_W] != '0);
    if (ov_q[COORD_W]) begin
      q_d = ng_q[COORD_W] ? $signed(QMIN) : $signed(QMAX);
    end else if (!ng_q[COORD_W]) begin
      q_d = qm[COORD_W-1] ? $signed(QMAX) : $signed(qm);
    end else if (tot > ((COORD_W+1)'(1) << (COORD_W - 1))) begin
      q_d = $signed(QMIN);
    end else begin
      q_d = $signed(COORD_W'(-tot));
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

// ----- rtl/ray_primitive_intersection.sv -----
// top level: ray to unit sphere / y=0 plane intersection pipeline
`timescale 1ns / 1ps
// A world-space ray (q16.16 origin and direction) enters with start and comes
// back as one result, strobed by res_valid_o for exactly one cycle, in the
// order the requests were taken. busy never rises: one request per clock is
// taken every cycle, and the result side has no backpressure, so a result
// must be captured on its strobe. Throughput is one ray per cycle; the
// longest parts are the 82-stage square root and the dividers with 32 quotient stages.
// The ray is first mapped to object space by the 3x4 inverse transform, then
// the sphere quadratic or the plane equation is solved. A miss reports
// hit_count 0 with both roots zero; roots are floored and saturated.
// Configuration writes are always ready (cfg_ready_o high) and take effect at
// once; they must only happen while no request is in flight. There is no
// clearing pass after reset.
module ray_primitive_intersection import rpi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rpi_req_t             req_i,
  output logic                 res_valid_o,
  output rpi_res_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // lane k of a transform row
  function automatic logic signed [LANE_W-1:0] lane_of(input logic [ROW_W-1:0] row,
                                                       input int k);
    return row[k*LANE_W +: LANE_W];
  endfunction

  // drop the q8.8 fraction (floor) and saturate to the object width
  function automatic logic signed [OBJ_W-1:0] map_clamp(input logic signed [MAP_W-1:0] acc);
    logic signed [MAP_W-1:0] shd;
    logic [MAP_W-OBJ_W:0]    hi;
    shd = acc >>> LANE_FRAC;
    hi  = shd[MAP_W-1:OBJ_W-1];
    if (hi == '0 || hi == '1) begin
      return shd[OBJ_W-1:0];
    end else if (shd[MAP_W-1]) begin
      return {1'b1, {(OBJ_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OBJ_W-1){1'b1}}};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row_q [3];
  prim_e            kind_q;
  logic [EPS_W-1:0] eps_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      kind_q   <= PRIM_SPHERE;
      eps_q    <= EPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW0: row_q[0] <= cfg_data_i;
        REG_ROW1: row_q[1] <= cfg_data_i;
        REG_ROW2: row_q[2] <= cfg_data_i;
        REG_KIND: kind_q   <= prim_e'(cfg_data_i[0]);
        REG_EPS:  eps_q    <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: transform products
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] wo [3];
  logic signed [COORD_W-1:0] wd [3];
  logic signed [PR_W-1:0]    po_q [3][3];
  logic signed [PR_W-1:0]    pd_q [3][3];
  logic signed [LANE_W-1:0]  tr_q [3];
  logic                      v1_q;

  assign wo[0] = req_i.origin_x;
  assign wo[1] = req_i.origin_y;
  assign wo[2] = req_i.origin_z;
  assign wd[0] = req_i.dir_x;
  assign wd[1] = req_i.dir_y;
  assign wd[2] = req_i.dir_z;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        po_q[r][j] <= lane_of(row_q[r], j) * wo[j];
        pd_q[r][j] <= lane_of(row_q[r], j) * wd[j];
      end
      tr_q[r] <= lane_of(row_q[r], 3);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: object-space origin and direction
  // ---------------------------------------------------------------------------
  logic signed [MAP_W-1:0] acc_o [3];
  logic signed [MAP_W-1:0] acc_d [3];
  logic signed [OBJ_W-1:0] o_q [3];
  logic signed [OBJ_W-1:0] d_q [3];
  logic                    v2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_o[r] = MAP_W'(po_q[r][0]) + MAP_W'(po_q[r][1]) + MAP_W'(po_q[r][2])
               + (MAP_W'(tr_q[r]) <<< FRAC_W);
      acc_d[r] = MAP_W'(pd_q[r][0]) + MAP_W'(pd_q[r][1]) + MAP_W'(pd_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      o_q[r] <= map_clamp(acc_o[r]);
      d_q[r] <= map_clamp(acc_d[r]);
    end
  end

  // ---------------------------------------------------------------------------
  // dot products d.d, d.o, o.o
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] dd [3];
  logic signed [PW-1:0] dov [3];
  logic signed [PW-1:0] oov [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rpi_mul u_mul_dd (.clk_i, .a_i(MW'(d_q[i])), .b_i(MW'(d_q[i])), .p_o(dd[i]));
    rpi_mul u_mul_do (.clk_i, .a_i(MW'(d_q[i])), .b_i(MW'(o_q[i])), .p_o(dov[i]));
    rpi_mul u_mul_oo (.clk_i, .a_i(MW'(o_q[i])), .b_i(MW'(o_q[i])), .p_o(oov[i]));
  end

  // plane terms and early miss ride alongside the multipliers
  logic signed [OBJ_W-1:0] dy;
  logic        [OBJ_W-1:0] dy_mag;
  logic                    dzero, pmiss, miss1;
  logic signed [PH_W-1:0]  ph_c;

  assign dy     = d_q[1];
  assign dy_mag = dy[OBJ_W-1] ? OBJ_W'(-dy) : OBJ_W'(dy);
  assign dzero  = (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);
  assign pmiss  = (dy == '0) || (dy_mag < OBJ_W'(eps_q));
  assign miss1  = (kind_q == PRIM_PLANE) ? pmiss : dzero;
  // sign chosen so that the root is -h / |dy|, like the sphere path with s = 0
  assign ph_c   = (dy > 0) ? PH_W'(o_q[1]) : -PH_W'(o_q[1]);

  logic                   k1_v_q  [MUL_LAT];
  logic                   k1_m_q  [MUL_LAT];
  logic signed [PH_W-1:0] k1_ph_q [MUL_LAT];
  logic [OBJ_W-1:0]       k1_pa_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    k1_m_q[0]  <= miss1;
    k1_ph_q[0] <= ph_c;
    k1_pa_q[0] <= dy_mag;
    for (int i = 1; i < MUL_LAT; i++) begin
      k1_m_q[i]  <= k1_m_q[i-1];
      k1_ph_q[i] <= k1_ph_q[i-1];
      k1_pa_q[i] <= k1_pa_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: a, h, c (plane reuses the a and h slots)
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] asum, hsum, csum;
  logic signed [MW-1:0] a3_q, h3_q, c3_q;
  logic                 m3_q, v3_q;

  assign asum = dd[0] + dd[1] + dd[2];
  assign hsum = dov[0] + dov[1] + dov[2];
  assign csum = oov[0] + oov[1] + oov[2] - (PW'(1) <<< (2 * FRAC_W));

  always_ff @(posedge clk_i) begin
    a3_q <= (kind_q == PRIM_PLANE) ? MW'(k1_pa_q[MUL_LAT-1]) : MW'(asum);
    h3_q <= (kind_q == PRIM_PLANE) ? MW'(k1_ph_q[MUL_LAT-1]) : MW'(hsum);
    c3_q <= MW'(csum);
    m3_q <= k1_m_q[MUL_LAT-1];
  end

  // ---------------------------------------------------------------------------
  // h*h and a*c
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] hh, ac;

  rpi_mul u_mul_hh (.clk_i, .a_i(h3_q), .b_i(h3_q), .p_o(hh));
  rpi_mul u_mul_ac (.clk_i, .a_i(a3_q), .b_i(c3_q), .p_o(ac));

  logic                 k2_v_q [MUL_LAT];
  logic                 k2_m_q [MUL_LAT];
  logic signed [MW-1:0] k2_h_q [MUL_LAT];
  logic signed [MW-1:0] k2_a_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    k2_m_q[0] <= m3_q;
    k2_h_q[0] <= h3_q;
    k2_a_q[0] <= a3_q;
    for (int i = 1; i < MUL_LAT; i++) begin
      k2_m_q[i] <= k2_m_q[i-1];
      k2_h_q[i] <= k2_h_q[i-1];
      k2_a_q[i] <= k2_a_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: discriminant, then the square root pipeline
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] disc;
  logic                 miss4;

  assign disc  = hh - ac;
  assign miss4 = k2_m_q[MUL_LAT-1] || ((kind_q == PRIM_SPHERE) && disc[PW-1]);

  logic [RAD_W-1:0]     rx_q [ROOT_W+1];
  logic [RAD_W-1:0]     rr_q [ROOT_W+1];
  logic signed [MW-1:0] sh_q [ROOT_W+1];
  logic signed [MW-1:0] sa_q [ROOT_W+1];
  logic                 sm_q [ROOT_W+1];
  logic                 sv_q [ROOT_W+1];

  always_ff @(posedge clk_i) begin
    // plane and misses take the root of zero
    rx_q[0] <= ((kind_q == PRIM_SPHERE) && !miss4) ? disc[RAD_W-1:0] : '0;
    rr_q[0] <= '0;
    sh_q[0] <= k2_h_q[MUL_LAT-1];
    sa_q[0] <= k2_a_q[MUL_LAT-1];
    sm_q[0] <= miss4;
  end

  // digit-by-digit root, one result bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int Bp = 2 * (ROOT_W - 1 - j);
    logic [RAD_W-1:0] trial;
    assign trial = rr_q[j] + (RAD_W'(1) << Bp);
    always_ff @(posedge clk_i) begin
      if (rx_q[j] >= trial) begin
        rx_q[j+1] <= rx_q[j] - trial;
        rr_q[j+1] <= (rr_q[j] >> 1) + (RAD_W'(1) << Bp);
      end else begin
        rx_q[j+1] <= rx_q[j];
        rr_q[j+1] <= rr_q[j] >> 1;
      end
      sh_q[j+1] <= sh_q[j];
      sa_q[j+1] <= sa_q[j];
      sm_q[j+1] <= sm_q[j];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else begin
        sv_q[j+1] <= sv_q[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: root numerators (-h -/+ s) scaled to the output fraction
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0]       sroot;
  logic signed [NUM_W-1:0] hx, sx;
  logic signed [NUM_W-1:0] nn_q, nf_q;
  logic [MW-1:0]           a5_q;
  logic                    m5_q, v5_q;

  assign sroot = rr_q[ROOT_W][ROOT_W-1:0];
  assign hx    = NUM_W'(sh_q[ROOT_W]);
  assign sx    = NUM_W'(sroot);

  always_ff @(posedge clk_i) begin
    nn_q <= (-hx - sx) <<< FRAC_W;
    nf_q <= (-hx + sx) <<< FRAC_W;
    a5_q <= sa_q[ROOT_W];
    m5_q <= sm_q[ROOT_W];
  end

  logic signed [COORD_W-1:0] qn, qf;

  rpi_div u_div_near (.clk_i, .num_i(nn_q), .den_i(a5_q), .q_o(qn));
  rpi_div u_div_far  (.clk_i, .num_i(nf_q), .den_i(a5_q), .q_o(qf));

  logic k3_v_q [DIV_LAT];
  logic k3_m_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    k3_m_q[0] <= m5_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      k3_m_q[i] <= k3_m_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  rpi_res_t res_q;
  logic     res_valid_q;

  always_ff @(posedge clk_i) begin
    if (k3_m_q[DIV_LAT-1]) begin
      res_q.hit_count <= HITS_NONE;
      res_q.t_near    <= '0;
      res_q.t_far     <= '0;
    end else begin
      res_q.hit_count <= (kind_q == PRIM_PLANE) ? HITS_PLANE : HITS_SPHERE;
      res_q.t_near    <= qn;
      res_q.t_far     <= qf;
    end
  end

  // valid bits travel with the request through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v5_q        <= 1'b0;
      sv_q[0]     <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MUL_LAT; i++) begin
        k1_v_q[i] <= 1'b0;
        k2_v_q[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_LAT; i++) begin
        k3_v_q[i] <= 1'b0;
      end
    end else begin
      v1_q      <= start && !busy;
      v2_q      <= v1_q;
      k1_v_q[0] <= v2_q;
      for (int i = 1; i < MUL_LAT; i++) begin
        k1_v_q[i] <= k1_v_q[i-1];
        k2_v_q[i] <= k2_v_q[i-1];
      end
      v3_q      <= k1_v_q[MUL_LAT-1];
      k2_v_q[0] <= v3_q;
      sv_q[0]   <= k2_v_q[MUL_LAT-1];
      v5_q      <= sv_q[ROOT_W];
      k3_v_q[0] <= v5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        k3_v_q[i] <= k3_v_q[i-1];
      end
      res_valid_q <= k3_v_q[DIV_LAT-1];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/rpi_checker.sv -----
// port-level checks for the intersection pipeline, bound to the top level
`timescale 1ns / 1ps
module rpi_checker import rpi_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     res_valid_o,
  input rpi_res_t res_o
);

  // every request comes back after the fixed latency
  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT res_valid_o)
    else $error("request produced no result at the pipeline latency");

  // no result without a request
  a_res_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit_count == HITS_NONE) |->
      (res_o.t_near == '0 && res_o.t_far == '0))
    else $error("miss with nonzero roots");

  a_plane_one_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit_count == HITS_PLANE) |-> (res_o.t_near == res_o.t_far))
    else $error("plane hit with differing roots");

  a_sphere_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.hit_count == HITS_SPHERE) |-> (res_o.t_near <= res_o.t_far))
    else $error("sphere roots out of order");

endmodule

bind ray_primitive_intersection rpi_checker u_rpi_checker (.*);

// ----- tb/ray_primitive_intersection_test.sv -----
// self-checking testbench of the ray/primitive intersection pipeline
`timescale 1ns / 1ps
module ray_primitive_intersection_test;
  import rpi_pkg::*;

  // wide signed scratch type for the exact integer prediction
  typedef logic signed [319:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [COORD_W-1:0] ONE_Q = 32'sh0001_0000;

  // one directed request with the configuration it runs under
  typedef struct {
    prim_e            kind;
    logic [EPS_W-1:0] eps;
    rpi_req_t         req;
    bit               known;
    rpi_res_t         res;
  } ray_row_t;

  logic clk_i, rst_ni, start, busy, res_valid_o, cfg_valid_i, cfg_ready_o;
  rpi_req_t req_i;
  rpi_res_t res_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  ray_primitive_intersection u_top (.*);

  // shadow copy of the register file
  logic [ROW_W-1:0] row_q [3];
  prim_e            kind_q;
  logic [EPS_W-1:0] eps_q;

  rpi_res_t hits_pending [$];
  ray_row_t ray_rows [$];
  bit       failed;
  bit       idle_en;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic wide_t sat(wide_t x, int bits);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic wide_t lane_val(logic [ROW_W-1:0] row, int k);
    return wide_t'($signed(row[LANE_W*k +: LANE_W]));
  endfunction

  // object-space coordinate: exact dot, floor of q8.8 scale, 40-bit saturation
  function automatic wide_t to_object(logic [ROW_W-1:0] row, wide_t v0, wide_t v1,
                                      wide_t v2, bit shift);
    wide_t acc;
    acc = lane_val(row, 0) * v0 + lane_val(row, 1) * v1 + lane_val(row, 2) * v2;
    if (shift) acc = acc + (lane_val(row, 3) <<< FRAC_W);
    acc = acc >>> LANE_FRAC;
    return sat(acc, OBJ_W);
  endfunction

  function automatic wide_t isqrt_floor(wide_t x);
    wide_t r, c;
    r = 0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (wide_t'(1) <<< i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic rpi_res_t predict_hit(rpi_req_t r);
    wide_t o [3], d [3], wo [3], wd [3];
    wide_t a, h, c, disc, s, dy, mag, num;
    rpi_res_t res;
    wo[0] = wide_t'(r.origin_x); wo[1] = wide_t'(r.origin_y); wo[2] = wide_t'(r.origin_z);
    wd[0] = wide_t'(r.dir_x);    wd[1] = wide_t'(r.dir_y);    wd[2] = wide_t'(r.dir_z);
    for (int i = 0; i < 3; i++) begin
      o[i] = to_object(row_q[i], wo[0], wo[1], wo[2], 1'b1);
      d[i] = to_object(row_q[i], wd[0], wd[1], wd[2], 1'b0);
    end
    res = '{HITS_NONE, '0, '0};
    if (kind_q == PRIM_SPHERE) begin
      a = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      h = d[0]*o[0] + d[1]*o[1] + d[2]*o[2];
      c = o[0]*o[0] + o[1]*o[1] + o[2]*o[2] - (wide_t'(1) <<< (2*FRAC_W));
      if (a != 0) begin
        disc = h*h - a*c;
        if (disc >= 0) begin
          s = isqrt_floor(disc);
          res.hit_count = HITS_SPHERE;
          res.t_near = COORD_W'(sat(floor_div((-h - s) <<< FRAC_W, a), COORD_W));
          res.t_far  = COORD_W'(sat(floor_div((-h + s) <<< FRAC_W, a), COORD_W));
        end
      end
    end else begin
      dy  = d[1];
      mag = dy < 0 ? -dy : dy;
      // parallel rays and rays under the epsilon miss
      if (dy != 0 && mag >= wide_t'(eps_q)) begin
        num = o[1] <<< FRAC_W;
        if (dy > 0) num = -num;
        res.hit_count = HITS_PLANE;
        res.t_near = COORD_W'(sat(floor_div(num, mag), COORD_W));
        res.t_far  = res.t_near;
      end
    end
    return res;
  endfunction

  // result checker: no stall possible, every strobe is a result
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (hits_pending.size() == 0) begin
        $error("unexpected result %p", res_o);
        failed = 1'b1;
      end else begin
        if (res_o.hit_count !== hits_pending[0].hit_count) begin
          $error("hit_count: expected %0d actual %0d", hits_pending[0].hit_count,
                 res_o.hit_count);
          failed = 1'b1;
        end
        if (res_o.t_near !== hits_pending[0].t_near) begin
          $error("t_near: expected %h actual %h", hits_pending[0].t_near, res_o.t_near);
          failed = 1'b1;
        end
        if (res_o.t_far !== hits_pending[0].t_far) begin
          $error("t_far: expected %h actual %h", hits_pending[0].t_far, res_o.t_far);
          failed = 1'b1;
        end
        void'(hits_pending.pop_front());
      end
    end
  end

  task automatic drain();
    while (hits_pending.size() != 0) @(posedge clk_i);
  endtask

  // register write; only called with no request in flight
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ROW0: row_q[0] = data;
      REG_ROW1: row_q[1] = data;
      REG_ROW2: row_q[2] = data;
      REG_KIND: kind_q = prim_e'(data[0]);
      REG_EPS:  eps_q = data[EPS_W-1:0];
      default: ;
    endcase
  endtask

  // issue one ray, queue its prediction, maybe follow with an idle burst
  task automatic send_ray(rpi_req_t r, bit known, rpi_res_t res);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    hits_pending = {hits_pending, predict_hit(r)};
    if (known && res !== hits_pending[$]) begin
      $error("hit_count/t_near/t_far: expected %p actual prediction %p", res,
             hits_pending[$]);
      failed = 1'b1;
      hits_pending[$] = res;
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  function automatic rpi_req_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    return '{ox, oy, oz, dx, dy, dz};
  endfunction

  task automatic add_row(prim_e k, int eps, rpi_req_t r, bit known, rpi_res_t res);
    ray_row_t entry;
    entry = '{k, eps[EPS_W-1:0], r, known, res};
    ray_rows = {ray_rows, entry};
  endtask

  // small coordinate in q16.16, within +-4.0
  function automatic int near_coord();
    return int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(int r);
    logic [ROW_W-1:0] row;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    for (int k = 0; k < 4; k++)
      row[LANE_W*k +: LANE_W] = LANE_W'(int'($urandom_range(0, 16'h400)) - 16'h200);
    // keep the diagonal strong so most maps stay well-conditioned
    if ($urandom_range(0, 1)) row[LANE_W*r +: LANE_W] = 16'h0100;
    return row;
  endfunction

  task automatic run_random(int n);
    rpi_req_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        r = mk_ray(near_coord(), near_coord(), near_coord(),
                   near_coord() / 2, near_coord() / 2, near_coord() / 2);
        if ($urandom_range(0, 9) == 0) r.dir_y = int'($urandom_range(0, 20)) - 10;
      end
      send_ray(r, 1'b0, '0);
    end
  endtask

  initial begin
    rpi_res_t miss;
    logic [ROW_W-1:0] rows [3];
    failed      = 1'b0;
    idle_en     = 1'b1;
    miss        = '{HITS_NONE, '0, '0};
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ROW0;
    cfg_data_i  = '0;
    row_q[0] = ROW0_RST; row_q[1] = ROW1_RST; row_q[2] = ROW2_RST;
    kind_q = PRIM_SPHERE;
    eps_q  = EPS_RST;

    // directed rays: sphere first, under the reset configuration
    add_row(PRIM_SPHERE, 7, mk_ray(0, 0, -2*ONE_Q, 0, 0, ONE_Q), 1,
            '{HITS_SPHERE, 32'sh1_0000, 32'sh3_0000});
    add_row(PRIM_SPHERE, 7, mk_ray(0, 2*ONE_Q, -2*ONE_Q, 0, 0, ONE_Q), 1, miss);
    add_row(PRIM_SPHERE, 7, mk_ray(0, 0, -2*ONE_Q, 0, 0, 0), 1, miss);
    // tangent ray gives two equal roots
    add_row(PRIM_SPHERE, 7, mk_ray(ONE_Q, 0, -2*ONE_Q, 0, 0, ONE_Q), 1,
            '{HITS_SPHERE, 32'sh2_0000, 32'sh2_0000});
    // origin inside: negative near root is kept
    add_row(PRIM_SPHERE, 7, mk_ray(0, 0, 0, ONE_Q, 0, 0), 1,
            '{HITS_SPHERE, -ONE_Q, ONE_Q});
    add_row(PRIM_SPHERE, 7, '{default: 32'h7fff_ffff}, 0, miss);
    add_row(PRIM_SPHERE, 7, '{default: 32'h8000_0000}, 0, miss);
    // tiny direction far away: roots saturate
    add_row(PRIM_SPHERE, 7, mk_ray(0, 0, 32'h8000_0001, 0, 0, 1), 0, miss);
    add_row(PRIM_SPHERE, 7, mk_ray(0, 0, 32'h7fff_ffff, 0, 0, -1), 0, miss);
    add_row(PRIM_PLANE, 7, mk_ray(0, ONE_Q, 0, 0, -ONE_Q, 0), 1,
            '{HITS_PLANE, ONE_Q, ONE_Q});
    add_row(PRIM_PLANE, 7, mk_ray(0, ONE_Q, 0, ONE_Q, 0, ONE_Q), 1, miss);
    // parallel threshold: just below, exactly at, and negative at epsilon
    add_row(PRIM_PLANE, 7, mk_ray(0, ONE_Q, 0, 0, 6, 0), 1, miss);
    add_row(PRIM_PLANE, 7, mk_ray(0, ONE_Q, 0, 0, 7, 0), 0, miss);
    add_row(PRIM_PLANE, 7, mk_ray(0, -ONE_Q, 0, 0, -7, 0), 0, miss);
    add_row(PRIM_PLANE, 0, mk_ray(0, 32'h7fff_ffff, 0, 0, 1, 0), 0, miss);
    add_row(PRIM_PLANE, 0, mk_ray(0, 32'h8000_0000, 0, 0, 1, 0), 0, miss);
    add_row(PRIM_PLANE, 0, '{default: 32'h8000_0000}, 0, miss);
    add_row(PRIM_PLANE, 16'hffff, mk_ray(0, ONE_Q, 0, 0, 32'h0000_ffff, 0), 0, miss);
    add_row(PRIM_PLANE, 16'hffff, mk_ray(0, ONE_Q, 0, 0, 32'hffff_0000, 0), 0, miss);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ray_rows[i]) begin
      if (ray_rows[i].kind != kind_q || ray_rows[i].eps != eps_q) begin
        start <= 1'b0;
        drain();
        write_reg(REG_KIND, CFG_W'(ray_rows[i].kind));
        write_reg(REG_EPS, CFG_W'(ray_rows[i].eps));
      end
      send_ray(ray_rows[i].req, ray_rows[i].known, ray_rows[i].res);
    end

    // random part over a sweep of configurations, extremes first
    for (int p = 0; p < 11; p++) begin
      start <= 1'b0;
      drain();
      case (p)
        0: begin rows[0] = '1; rows[1] = '1; rows[2] = '1; end
        1: begin rows = '{default: 64'h7fff_7fff_7fff_7fff}; end
        2: begin rows = '{default: 64'h8000_8000_8000_8000}; end
        3: begin rows = '{default: '0}; end
        4: begin rows[0] = ROW0_RST; rows[1] = ROW1_RST; rows[2] = ROW2_RST; end
        default: for (int r = 0; r < 3; r++) rows[r] = rand_row(r);
      endcase
      write_reg(REG_ROW0, rows[0]);
      write_reg(REG_ROW1, rows[1]);
      write_reg(REG_ROW2, rows[2]);
      write_reg(REG_KIND, CFG_W'(p % 2));
      write_reg(REG_EPS, p == 5 ? CFG_W'(16'hffff) : p == 7 ? '0 : CFG_W'($urandom_range(0, 64)));
      if (p == 6) write_reg(cfg_reg_e'(REG_UNUSED), {$urandom, $urandom});
      // final stretch runs back to back
      idle_en = (p != 10);
      run_random(45);
    end
    start <= 1'b0;

    drain();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (!failed && hits_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
